[sv/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
// All checks are sampled on clk and skipped while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising edge of clk.
`define FSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define FSP_ASSERT_NEVER(label, cond, msg) \
  `FSP_ASSERT(label, !(cond), msg)

`endif

[sv/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, codes and helper functions shared by the format printer modules.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int MAX_FIELD = 48;
  localparam int FIELD_W   = 6;
  localparam int COUNT_W   = 31;
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW   = 2;
  localparam int DIG_N     = 10;

  // command codes
  localparam logic [2:0] CMD_FMT   = 3'd0;
  localparam logic [2:0] CMD_INT   = 3'd1;
  localparam logic [2:0] CMD_SSTRT = 3'd2;
  localparam logic [2:0] CMD_SCHR  = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;

  // characters
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  char_value;
    logic [31:0] arg_value;
    logic        null_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_char;
    logic               last;
    logic               done_res;
    logic [COUNT_W-1:0] total_count;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,
    JOB_INT  = 2'd1,
    JOB_STR  = 2'd2,
    JOB_DONE = 2'd3
  } job_kind_t;

  // work handed from the parser to the emitter
  typedef struct packed {
    job_kind_t          kind;
    logic [7:0]         ch;
    logic [31:0]        arg;
    logic               hex;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] prec;
    logic               prec_given;
    logic [FIELD_W-1:0] pad;
    logic [2:0]         txt_n;
  } job_t;

  // width/precision digit accumulate, saturating
  function automatic logic [FIELD_W-1:0] add_digit(input logic [FIELD_W-1:0] v,
                                                   input logic [3:0] d);
    logic [9:0] r;
    r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {6'b0, d};
    return (r > 10'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : r[FIELD_W-1:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h57 + {4'b0, d});
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

[sv/fsp_front.sv]
// ----------------------------------------------------------------------------
// fsp_front
// Format parser: takes one item per cycle while accept is high, tracks the
// conversion spec and hands emit work to the job queue.
// ----------------------------------------------------------------------------
module fsp_front import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output job_t     job
);

  typedef enum logic [5:0] {
    PH_LIT   = 6'b000001,
    PH_WIDTH = 6'b000010,
    PH_PREC  = 6'b000100,
    PH_INT   = 6'b001000,
    PH_STR   = 6'b010000,
    PH_SCHR  = 6'b100000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [FIELD_W-1:0] width_r, width_nxt;
  logic [FIELD_W-1:0] prec_r, prec_nxt;
  logic               pg_r, pg_nxt;
  logic               hex_r, hex_nxt;
  logic [31:0]        left_r, left_nxt;
  logic [31:0]        emit_r, emit_nxt;

  logic        lit;
  logic        is_digit;
  logic        is_conv;
  logic [31:0] slen;
  logic [7:0]  c;

  assign c        = item.char_value;
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign is_conv  = (c == CH_S) || (c == CH_D) || (c == CH_X);

  // parse step
  always_comb begin
    phase_nxt = phase_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    pg_nxt    = pg_r;
    hex_nxt   = hex_r;
    left_nxt  = left_r;
    emit_nxt  = emit_r;
    job_push  = 1'b0;
    job       = '0;
    job.ch    = c;
    job.arg   = item.arg_value;
    job.hex   = hex_r;
    job.width = width_r;
    job.prec  = prec_r;
    job.prec_given = pg_r;
    lit       = 1'b0;
    slen      = item.null_string ? 32'd6 : item.arg_value;
    if (pg_r && ({26'b0, prec_r} < slen)) begin
      slen = {26'b0, prec_r};
    end
    if (accept) begin
      case (item.command)
        CMD_FMT: begin
          lit = 1'b1;
          if (phase_r == PH_WIDTH || phase_r == PH_PREC) begin
            if (is_digit) begin
              lit = 1'b0;
              if (phase_r == PH_WIDTH) begin
                width_nxt = add_digit(width_r, c[3:0]);
              end else begin
                prec_nxt = add_digit(prec_r, c[3:0]);
              end
            end else if (c == CH_DOT && phase_r == PH_WIDTH) begin
              lit       = 1'b0;
              pg_nxt    = 1'b1;
              phase_nxt = PH_PREC;
            end else if (is_conv) begin
              lit       = 1'b0;
              phase_nxt = (c == CH_S) ? PH_STR : PH_INT;
              hex_nxt   = (c == CH_X);
            end
          end
        end
        CMD_INT: begin
          if (phase_r == PH_INT) begin
            phase_nxt = PH_LIT;
            hex_nxt   = 1'b0;
            job.kind  = JOB_INT;
            job_push  = !((item.arg_value == 32'd0) && pg_r && (prec_r == '0) &&
                          (width_r == '0));
          end
        end
        CMD_SSTRT: begin
          if (phase_r == PH_STR) begin
            job.kind  = JOB_STR;
            job.pad   = ({26'b0, width_r} > slen) ? (width_r - slen[FIELD_W-1:0]) : '0;
            job.txt_n = item.null_string ? ((slen < 32'd6) ? slen[2:0] : 3'd6) : 3'd0;
            job_push  = (job.pad != '0) || (job.txt_n != 3'd0);
            phase_nxt = PH_LIT;
            hex_nxt   = 1'b0;
            if (!item.null_string && item.arg_value != 32'd0) begin
              phase_nxt = PH_SCHR;
              left_nxt  = item.arg_value;
              emit_nxt  = slen;
            end
          end
        end
        CMD_SCHR: begin
          if (phase_r == PH_SCHR) begin
            if (emit_r != 32'd0) begin
              job.kind = JOB_CHAR;
              job_push = 1'b1;
              emit_nxt = emit_r - 32'd1;
            end
            left_nxt = left_r - 32'd1;
            if (left_r == 32'd1) begin
              phase_nxt = PH_LIT;
              emit_nxt  = '0;
            end
          end
        end
        CMD_END: begin
          job.kind  = JOB_DONE;
          job_push  = 1'b1;
          phase_nxt = PH_LIT;
          width_nxt = '0;
          prec_nxt  = '0;
          pg_nxt    = 1'b0;
          hex_nxt   = 1'b0;
          left_nxt  = '0;
          emit_nxt  = '0;
        end
        default: ;
      endcase
      // literal text, or a spec that ended on an unknown letter
      if (lit) begin
        phase_nxt = PH_LIT;
        hex_nxt   = 1'b0;
        left_nxt  = '0;
        emit_nxt  = '0;
        if (c == CH_PCT) begin
          phase_nxt = PH_WIDTH;
          width_nxt = '0;
          prec_nxt  = '0;
          pg_nxt    = 1'b0;
        end else begin
          job.kind = JOB_CHAR;
          job_push = 1'b1;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LIT;
      width_r <= '0;
      prec_r  <= '0;
      pg_r    <= 1'b0;
      hex_r   <= 1'b0;
      left_r  <= '0;
      emit_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
      pg_r    <= pg_nxt;
      hex_r   <= hex_nxt;
      left_r  <= left_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

[sv/fsp_jobq.sv]
// ----------------------------------------------------------------------------
// fsp_jobq
// Small register FIFO of jobs between the parser and the emitter.
// ----------------------------------------------------------------------------
module fsp_jobq import fsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic full,
  output logic empty
);

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wp_r, rp_r;
  logic [JOBQ_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (JOBQ_AW+1)'(do_push) - (JOBQ_AW+1)'(do_pop);
    end
  end

endmodule

[sv/fsp_back.sv]
// ----------------------------------------------------------------------------
// fsp_back
// Emitter: expands jobs into characters, one per cycle while the output
// register is free, converts integers one digit per cycle and holds the
// output register and running count.
module fsp_back import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic               hex_r, hex_nxt;
  logic               str_r, str_nxt;
  logic [FIELD_W-1:0] width_r, width_nxt;
  logic [FIELD_W-1:0] prec_r, prec_nxt;
  logic [3:0]         len_r, len_nxt;
  logic [FIELD_W-1:0] pad_r, pad_nxt;
  logic               sign_r, sign_nxt;
  logic [FIELD_W-1:0] zeros_r, zeros_nxt;
  logic [3:0]         dig_r, dig_nxt;
  logic [2:0]         txt_r, txt_nxt;
  logic [3:0]         buf_r [DIG_N];
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               can_emit;
  logic               emit;
  out_item_t          emit_data;
  logic               buf_we;
  logic [3:0]         digit;
  logic [31:0]        quot;
  logic [63:0]        prod;
  logic [31:0]        rem32;
  logic [6:0]         total;
  logic [COUNT_W-1:0] count_inc;

  assign empty     = !out_valid_r;
  assign out_data  = out_r;
  assign can_emit  = !out_valid_r || pop;
  assign count_inc = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;

  // divide by ten through the reciprocal, exact for 32-bit values
  assign prod  = {32'b0, mag_r} * 64'h0000_0000_CCCC_CCCD;
  assign quot  = {3'b0, prod[63:35]};
  assign rem32 = mag_r - (quot << 3) - (quot << 1);
  assign digit = hex_r ? mag_r[3:0] : rem32[3:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    hex_nxt   = hex_r;
    str_nxt   = str_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    len_nxt   = len_r;
    pad_nxt   = pad_r;
    sign_nxt  = sign_r;
    zeros_nxt = zeros_r;
    dig_nxt   = dig_r;
    txt_nxt   = txt_r;
    count_nxt = count_r;
    job_pop   = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    buf_we    = 1'b0;
    total     = 7'({1'b0, zeros_r}) + 7'(len_r) + 7'(neg_r);
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          case (job.kind)
            JOB_CHAR: begin
              if (can_emit) begin
                job_pop   = 1'b1;
                emit      = 1'b1;
                count_nxt = count_inc;
                emit_data.out_char    = job.ch;
                emit_data.last        = 1'b1;
                emit_data.total_count = count_inc;
              end
            end
            JOB_DONE: begin
              if (can_emit) begin
                job_pop   = 1'b1;
                emit      = 1'b1;
                count_nxt = '0;
                emit_data.last        = 1'b1;
                emit_data.done_res    = 1'b1;
                emit_data.total_count = count_r;
              end
            end
            JOB_INT: begin
              job_pop   = 1'b1;
              hex_nxt   = job.hex;
              width_nxt = job.width;
              prec_nxt  = job.prec;
              str_nxt   = 1'b0;
              neg_nxt   = !job.hex && job.arg[31];
              mag_nxt   = (!job.hex && job.arg[31]) ? (32'd0 - job.arg) : job.arg;
              len_nxt   = '0;
              sign_nxt  = 1'b0;
              zeros_nxt = '0;
              dig_nxt   = '0;
              if (job.arg == 32'd0 && job.prec_given && job.prec == '0) begin
                // zero value printed with zero precision: padding only
                pad_nxt   = job.width;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_CONV;
              end
            end
            default: begin
              job_pop   = 1'b1;
              str_nxt   = 1'b1;
              pad_nxt   = job.pad;
              sign_nxt  = 1'b0;
              zeros_nxt = '0;
              dig_nxt   = {1'b0, job.txt_n};
              txt_nxt   = job.txt_n;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_CONV: begin
        buf_we  = 1'b1;
        len_nxt = len_r + 4'd1;
        mag_nxt = hex_r ? (mag_r >> 4) : quot;
        if (mag_nxt == 32'd0 || len_nxt == 4'(DIG_N)) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        zeros_nxt = (prec_r > {2'b0, len_r}) ? (prec_r - {2'b0, len_r}) : '0;
        total     = 7'({1'b0, zeros_nxt}) + 7'(len_r) + 7'(neg_r);
        pad_nxt   = (7'(width_r) > total) ? (width_r - total[FIELD_W-1:0]) : '0;
        sign_nxt  = neg_r;
        dig_nxt   = len_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          count_nxt = count_inc;
          emit_data.total_count = count_inc;
          if (pad_r != '0) begin
            emit_data.out_char = CH_SPACE;
            pad_nxt = pad_r - 1'b1;
          end else if (sign_r) begin
            emit_data.out_char = CH_MINUS;
            sign_nxt = 1'b0;
          end else if (zeros_r != '0) begin
            emit_data.out_char = CH_0;
            zeros_nxt = zeros_r - 1'b1;
          end else begin
            emit_data.out_char = str_r ? null_char(txt_r - dig_r[2:0])
                                       : hex_char(buf_r[dig_r - 4'd1]);
            dig_nxt = dig_r - 4'd1;
          end
          emit_data.last = (pad_nxt == '0) && !sign_nxt && (zeros_nxt == '0) &&
                           (dig_nxt == '0);
          if (emit_data.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[len_r] <= digit;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    hex_r   <= hex_nxt;
    str_r   <= str_nxt;
    width_r <= width_nxt;
    prec_r  <= prec_nxt;
    len_r   <= len_nxt;
    pad_r   <= pad_nxt;
    sign_r  <= sign_nxt;
    zeros_r <= zeros_nxt;
    dig_r   <= dig_nxt;
    txt_r   <= txt_nxt;
    if (emit) begin
      out_r <= emit_data;
    end
  end

  // control state and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[sv/format_string_printer.sv]
// ----------------------------------------------------------------------------
// format_string_printer
// Printf subset formatter (%s, %d, %x with width and precision).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full, in_data): format characters, integer and string
//   arguments, string characters and end of format, one beat per item. The
//   parser takes one beat per cycle while full is low.
//   Result channel (empty/pop, out_data): one beat per emitted character;
//   last marks the final beat caused by an item, done_res the single beat
//   answering end of format, which also clears the running count.
//   Path: a character item is written into the job queue when accepted,
//   then into the output register, from which it can be popped. An
//   integer adds a setup step, a conversion step per digit (up to 10
//   decimal or 8 hex, one divide by ten per cycle) and a sizing step
//   before its first character. Throughput: the emitter produces one
//   character per cycle while the output register is empty or popped.
//   A four-entry job queue lets the parser run ahead of the emitter.
//   Reset (rst_n low, synchronous) empties the queue and the output register
//   and returns the parser to literal text. When pop stays low the output
//   beat holds, the emitter stops, the queue fills and full rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module format_string_printer import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic accept;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;
  logic out_fire;
  logic done_ok;
  logic count_low;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign out_fire  = pop && !empty;
  assign done_ok   = (out_data.out_char == 8'd0) && out_data.last;
  assign count_low = empty || (out_data.total_count <= 31'd1);

  // parser
  fsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .job_push (q_push),
    .job      (q_wdata)
  );

  // job queue
  fsp_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // emitter
  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (q_rdata),
    .job_pop   (q_pop),
    .pop       (out_fire),
    .empty     (empty),
    .out_data  (out_data)
  );

  // checks
  `FSP_ASSERT_NEVER(a_push_full, q_push && q_full, "job pushed into full queue")
  `FSP_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "job popped from empty queue")
  `FSP_ASSERT_NEVER(a_done_beat, !empty && out_data.done_res && !done_ok, "bad done beat")
  `FSP_ASSERT(a_count_clr, (out_fire && out_data.done_res) |=> count_low, "count not cleared")

endmodule

[test/format_string_printer_tb.sv]
// ----------------------------------------------------------------------------
// format_string_printer_tb
// Checks the printf subset formatter beat by beat against a behavioral
// model of the parser and emitter, running directed and random format
// streams through several idle and stall phases.
// ----------------------------------------------------------------------------
module format_string_printer_tb;
  import fsp_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 108;

  // parse phases of the model
  typedef enum logic [2:0] {
    PH_LIT, PH_WIDTH, PH_PREC, PH_INT, PH_STR, PH_SCHR
  } phase_t;
  typedef enum logic [1:0] { KD_NONE, KD_S, KD_D, KD_X } kind_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_item_t in_data;
  logic empty;
  logic pop;
  out_item_t out_data;

  format_string_printer uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // formatter model state
  phase_t fmt_phase;
  int unsigned fmt_width;
  int unsigned fmt_prec;
  bit fmt_prec_given;
  kind_t fmt_kind;
  logic [31:0] str_left;
  logic [31:0] str_emit_left;
  logic [COUNT_W-1:0] char_count;

  in_item_t pending_items[$];
  out_item_t expected_chars[$];
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_until_drained;
  int errors;
  int idle_cycles;

  function automatic void put_char(input logic [7:0] ch, inout int n);
    out_item_t r;
    if (n >= 59) return;
    if (char_count != {COUNT_W{1'b1}}) char_count++;
    r.out_char = ch;
    r.last = 1'b0;
    r.done_res = 1'b0;
    r.total_count = char_count;
    expected_chars.push_back(r);
    n++;
  endfunction

  function automatic int unsigned sat_digit(input int unsigned v, input int unsigned d);
    int unsigned r;
    r = v * 10 + d;
    return (r > MAX_FIELD) ? MAX_FIELD : r;
  endfunction

  function automatic void model_clear();
    fmt_phase = PH_LIT;
    fmt_width = 0;
    fmt_prec = 0;
    fmt_prec_given = 0;
    fmt_kind = KD_NONE;
    str_left = 0;
    str_emit_left = 0;
    char_count = 0;
  endfunction

  function automatic bit take_letter(input logic [7:0] c);
    if (c == CH_S) begin fmt_kind = KD_S; fmt_phase = PH_STR; return 1'b1; end
    if (c == CH_D) begin fmt_kind = KD_D; fmt_phase = PH_INT; return 1'b1; end
    if (c == CH_X) begin fmt_kind = KD_X; fmt_phase = PH_INT; return 1'b1; end
    return 1'b0;
  endfunction

  function automatic void predict_format_char(input logic [7:0] c, inout int n);
    bit dig;
    dig = (c >= CH_0) && (c <= CH_9);
    if (fmt_phase == PH_WIDTH) begin
      if (dig) begin fmt_width = sat_digit(fmt_width, c - CH_0); return; end
      if (c == CH_DOT) begin fmt_prec_given = 1; fmt_phase = PH_PREC; return; end
      if (take_letter(c)) return;
    end else if (fmt_phase == PH_PREC) begin
      if (dig) begin fmt_prec = sat_digit(fmt_prec, c - CH_0); return; end
      if (take_letter(c)) return;
    end
    // literal text
    fmt_phase = PH_LIT;
    fmt_kind = KD_NONE;
    str_left = 0;
    str_emit_left = 0;
    if (c == CH_PCT) begin
      fmt_phase = PH_WIDTH;
      fmt_width = 0;
      fmt_prec = 0;
      fmt_prec_given = 0;
    end else begin
      put_char(c, n);
    end
  endfunction

  function automatic void predict_integer(input logic [31:0] raw, inout int n);
    bit neg;
    logic [31:0] mag;
    int unsigned base;
    int unsigned len;
    int unsigned zeros;
    int unsigned total;
    logic [7:0] digits[10];
    string hex_set;
    hex_set = "0123456789abcdef";
    neg = 0;
    mag = raw;
    base = 10;
    len = 0;
    if (fmt_kind == KD_X) base = 16;
    else if (raw[31]) begin neg = 1; mag = -raw; end
    if (raw == 0 && fmt_prec_given && fmt_prec == 0) begin
      for (int i = 0; i < fmt_width; i++) put_char(CH_SPACE, n);
      return;
    end
    do begin
      digits[len] = hex_set[mag % base];
      len++;
      mag = mag / base;
    end while (mag != 0 && len < 10);
    zeros = (fmt_prec > len) ? fmt_prec - len : 0;
    total = zeros + len + (neg ? 1 : 0);
    for (int i = total; i < fmt_width; i++) put_char(CH_SPACE, n);
    if (neg) put_char(CH_MINUS, n);
    for (int i = 0; i < zeros; i++) put_char(CH_0, n);
    while (len > 0) begin
      len--;
      put_char(digits[len], n);
    end
  endfunction

  function automatic void predict_string_start(input logic [31:0] length, input bit is_null,
                                               inout int n);
    logic [31:0] len;
    string null_txt;
    null_txt = "(null)";
    len = is_null ? 32'd6 : length;
    if (fmt_prec_given && fmt_prec < len) len = fmt_prec;
    for (longint i = len; i < fmt_width; i++) put_char(CH_SPACE, n);
    fmt_phase = PH_LIT;
    fmt_kind = KD_NONE;
    if (is_null) begin
      for (int i = 0; i < len && i < 6; i++) put_char(null_txt[i], n);
      return;
    end
    if (length != 0) begin
      fmt_phase = PH_SCHR;
      str_left = length;
      str_emit_left = len;
    end
  endfunction

  // expected beats for one accepted input item
  function automatic void predict_item(input in_item_t it);
    int n;
    out_item_t r;
    n = 0;
    case (it.command)
      CMD_FMT: predict_format_char(it.char_value, n);
      CMD_INT: if (fmt_phase == PH_INT) begin
        predict_integer(it.arg_value, n);
        fmt_phase = PH_LIT;
        fmt_kind = KD_NONE;
      end
      CMD_SSTRT: if (fmt_phase == PH_STR)
        predict_string_start(it.arg_value, it.null_string, n);
      CMD_SCHR: if (fmt_phase == PH_SCHR) begin
        if (str_emit_left > 0) begin
          put_char(it.char_value, n);
          str_emit_left--;
        end
        if (str_left > 0) str_left--;
        if (str_left == 0) begin
          fmt_phase = PH_LIT;
          str_emit_left = 0;
        end
      end
      CMD_END: begin
        r.out_char = 8'd0;
        r.last = 1'b1;
        r.done_res = 1'b1;
        r.total_count = char_count;
        expected_chars.push_back(r);
        model_clear();
        return;
      end
      default: ;
    endcase
    if (n > 0) expected_chars[$].last = 1'b1;
  endfunction

  // input beat taken at the last rising edge
  logic accepted_in;
  always @(posedge clk) begin
    accepted_in <= rst_n && push && !full;
  end

  // driver: a new beat once the current one is taken, and a random pop
  always @(negedge clk) begin
    if (!rst_n) begin
      push    <= 1'b0;
      pop     <= 1'b0;
      in_data <= '0;
    end else begin
      if (!push || accepted_in) begin
        if (pending_items.size() > 0 && !(hold_until_drained && expected_chars.size() > 0)
            && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted pushes, check accepted pops
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (push && !full) predict_item(in_data);
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected beat out_char=%h", out_data.out_char);
          errors++;
        end else begin
          exp_r = expected_chars.pop_front();
          if (out_data.out_char !== exp_r.out_char) begin
            $error("out_char expected %h actual %h", exp_r.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.last !== exp_r.last) begin
            $error("last expected %b actual %b", exp_r.last, out_data.last);
            errors++;
          end
          if (out_data.done_res !== exp_r.done_res) begin
            $error("done_res expected %b actual %b", exp_r.done_res, out_data.done_res);
            errors++;
          end
          if (out_data.total_count !== exp_r.total_count) begin
            $error("total_count expected %0d actual %0d", exp_r.total_count,
                   out_data.total_count);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("format_string_printer: mismatch");
      $finish;
    end
  end

  function automatic in_item_t mk(input int unsigned cmd, input int unsigned ch,
                                  input int unsigned arg, input int unsigned nul);
    in_item_t it;
    it.command = 3'(cmd);
    it.char_value = 8'(ch);
    it.arg_value = arg;
    it.null_string = nul[0];
    return it;
  endfunction

  function automatic void add_fmt(input string s);
    for (int i = 0; i < s.len(); i++) pending_items.push_back(mk(CMD_FMT, s[i], 0, 0));
  endfunction

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(4))
      0: return $urandom_range(9);
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return -$urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  // one random spec: mostly well formed, sometimes broken
  function automatic void add_random_spec();
    string spec;
    int wsel;
    int len;
    spec = "%";
    wsel = $urandom_range(9);
    if (wsel < 4) spec = {spec, $sformatf("%0d", $urandom_range(12))};
    else if (wsel == 4) spec = {spec, $sformatf("%0d", $urandom_range(99))};
    if ($urandom_range(2) == 0)
      spec = {spec, ".", ($urandom_range(3) == 0) ? "" : $sformatf("%0d", $urandom_range(14))};
    case ($urandom_range(9))
      0, 1, 2: begin
        spec = {spec, "s"};
        add_fmt(spec);
        if ($urandom_range(4) == 0) begin
          pending_items.push_back(mk(CMD_SSTRT, $urandom, $urandom_range(9), 1));
        end else begin
          len = $urandom_range(5);
          pending_items.push_back(mk(CMD_SSTRT, $urandom, len, 0));
          for (int i = 0; i < len; i++)
            pending_items.push_back(mk(CMD_SCHR, $urandom, $urandom, $urandom));
        end
      end
      3, 4, 5: begin
        add_fmt({spec, "d"});
        pending_items.push_back(mk(CMD_INT, $urandom, rand_arg(), $urandom));
      end
      6, 7: begin
        add_fmt({spec, "x"});
        pending_items.push_back(mk(CMD_INT, $urandom, rand_arg(), $urandom));
      end
      default: begin
        // noise: random commands and bytes, possibly broken specs
        add_fmt(spec);
        pending_items.push_back(mk($urandom, $urandom, $urandom, $urandom));
      end
    endcase
    if ($urandom_range(1) == 0) pending_items.push_back(mk(CMD_FMT, $urandom_range(32, 126), 0, 0));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || push || expected_chars.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_until_drained = 0;
    model_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, null string, zero value, unknown letter, drop
    add_fmt("A%99.99d");
    pending_items.push_back(mk(CMD_INT, 0, 32'h8000_0000, 0));
    add_fmt("%.0d");
    pending_items.push_back(mk(CMD_INT, 0, 0, 0));
    add_fmt("%5.0x");
    pending_items.push_back(mk(CMD_INT, 0, 0, 0));
    add_fmt("%x");
    pending_items.push_back(mk(CMD_INT, 0, 32'hffff_ffff, 0));
    add_fmt("%8.3s");
    pending_items.push_back(mk(CMD_SSTRT, 0, 0, 1));
    add_fmt("%3s");
    pending_items.push_back(mk(CMD_SSTRT, 0, 0, 0));
    add_fmt("%q%%d");
    pending_items.push_back(mk(CMD_INT, 0, 32'h7fff_ffff, 1));
    pending_items.push_back(mk(CMD_SCHR, 8'hff, 0, 0));
    pending_items.push_back(mk(3'd7, 8'hff, 32'hffff_ffff, 1));
    add_fmt("%2s");
    pending_items.push_back(mk(CMD_SSTRT, 0, 32'd2, 0));
    pending_items.push_back(mk(CMD_SCHR, 8'h00, 0, 0));
    add_fmt("Z%1");
    pending_items.push_back(mk(CMD_END, 0, 0, 0));
    wait_drained();

    // in the first random phase, pause sending until all results have drained
    hold_until_drained = 1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      target = pending_items.size() + PHASE_ITEMS;
      while (pending_items.size() < target) begin
        add_random_spec();
        if ($urandom_range(15) == 0) pending_items.push_back(mk(CMD_END, $urandom, $urandom, 0));
      end
      wait_drained();
      hold_until_drained = 0;
    end
    if (errors == 0) begin
      $display("format_string_printer: match");
    end else begin
      $display("format_string_printer: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/fsp_pkg.sv
sv/fsp_front.sv
sv/fsp_jobq.sv
sv/fsp_back.sv
sv/format_string_printer.sv
test/format_string_printer_tb.sv
